>>> sv/altitude_inertial_filter_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the altitude inertial filter
// Concurrent assertion forms used by the filter's controller.
// ---------------------------------------------------------------------------
`ifndef ALTITUDE_INERTIAL_FILTER_CORE_MACROS_SVH
`define ALTITUDE_INERTIAL_FILTER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AIF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aif assertion failed");

// Next-cycle implication, checked outside reset.
`define AIF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aif assertion failed");

`endif

>>> sv/aif_pkg.sv
// ---------------------------------------------------------------------------
// Altitude inertial filter package
// Shared command type, operation codes, register indexes and saturation.
// ---------------------------------------------------------------------------
package aif_pkg;

    localparam int WW = 68;
    typedef logic signed [WW-1:0] wide_t;

    localparam logic [1:0] REG_BARO_W  = 2'd0;
    localparam logic [1:0] REG_ACCEL_W = 2'd1;
    localparam logic [1:0] REG_BIAS_W  = 2'd2;
    localparam logic [1:0] REG_GRAVITY = 2'd3;

    localparam logic [4:0] OP_BARO  = 5'd0;
    localparam logic [4:0] OP_SUM   = 5'd1;
    localparam logic [4:0] OP_ACORR = 5'd2;
    localparam logic [4:0] OP_T1    = 5'd3;
    localparam logic [4:0] OP_T2    = 5'd4;
    localparam logic [4:0] OP_UA    = 5'd5;
    localparam logic [4:0] OP_UB    = 5'd6;
    localparam logic [4:0] OP_UC    = 5'd7;
    localparam logic [4:0] OP_AD    = 5'd8;
    localparam logic [4:0] OP_VD    = 5'd9;
    localparam logic [4:0] OP_PRED  = 5'd10;
    localparam logic [4:0] OP_BQ1   = 5'd11;
    localparam logic [4:0] OP_BQ2   = 5'd12;
    localparam logic [4:0] OP_BM    = 5'd13;
    localparam logic [4:0] OP_BY    = 5'd14;
    localparam logic [4:0] OP_DIV3  = 5'd15;
    localparam logic [4:0] OP_AQ1   = 5'd16;
    localparam logic [4:0] OP_AQ2   = 5'd17;

    // Magic multiplier for signed truncating division by three.
    localparam logic signed [32:0] DIV3_MAGIC = 33'sh055555556;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] lane;
        logic       wb;
        logic       capture;
        logic       load_out;
    } cmd_t;

    function automatic logic signed [31:0] sat32(input wide_t x);
        if (x > wide_t'(32'sh7fffffff))
        begin
            return 32'sh7fffffff;
        end
        if (x < wide_t'(-32'sh7fffffff - 32'sh1))
        begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

>>> sv/aif_if.sv
// ---------------------------------------------------------------------------
// Altitude inertial filter channel interfaces
// Input tick channel and estimate result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface aif_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        elapsed;
    logic               ready_req;
    logic               baro_valid;
    logic signed [31:0] baro_altitude;
    logic               accel_valid;
    logic signed [23:0] accel_x;
    logic signed [23:0] accel_y;
    logic signed [23:0] accel_z;
    logic signed [15:0] rot_x_col;
    logic signed [15:0] rot_y_col;
    logic signed [15:0] rot_z_col;

    modport source (output valid, elapsed, ready_req, baro_valid, baro_altitude,
                    accel_valid, accel_x, accel_y, accel_z, rot_x_col, rot_y_col,
                    rot_z_col, input ready);
    modport sink (input valid, elapsed, ready_req, baro_valid, baro_altitude,
                  accel_valid, accel_x, accel_y, accel_z, rot_x_col, rot_y_col,
                  rot_z_col, output ready);
endinterface

interface aif_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] est_position;
    logic signed [31:0] est_velocity;
    logic signed [31:0] est_accel;
    logic               updated;

    modport source (output valid, est_position, est_velocity, est_accel, updated,
                    input ready);
    modport sink (input valid, est_position, est_velocity, est_accel, updated,
                  output ready);
endinterface

>>> sv/aif_ctrl.sv
// ---------------------------------------------------------------------------
// Altitude inertial filter controller
// Sequences the datapath operations of one tick and owns the handshakes.
// ---------------------------------------------------------------------------
`include "altitude_inertial_filter_core_macros.svh"

module aif_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_ready_req,
    output logic          out_valid,
    input  logic          out_ready,
    output aif_pkg::cmd_t cmd
);
    import aif_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [4:0] LAST_STEP = 5'd25;

    logic [1:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;
    logic [4:0] op_sel;
    logic [1:0] lane_sel;
    logic       accept;

    // Fixed program of one tick, one operation per step.
    always_comb
    begin
        lane_sel = 2'd0;
        case (step_reg)
            5'd0:  op_sel = OP_BARO;
            5'd1:  op_sel = OP_SUM;
            5'd2:  begin op_sel = OP_SUM; lane_sel = 2'd1; end
            5'd3:  begin op_sel = OP_SUM; lane_sel = 2'd2; end
            5'd4:  op_sel = OP_ACORR;
            5'd5:  op_sel = OP_T1;
            5'd6:  op_sel = OP_T2;
            5'd7:  op_sel = OP_UA;
            5'd8:  op_sel = OP_UB;
            5'd9:  op_sel = OP_UC;
            5'd10: begin op_sel = OP_UA; lane_sel = 2'd1; end
            5'd11: begin op_sel = OP_UB; lane_sel = 2'd1; end
            5'd12: begin op_sel = OP_UC; lane_sel = 2'd1; end
            5'd13: begin op_sel = OP_UA; lane_sel = 2'd2; end
            5'd14: begin op_sel = OP_UB; lane_sel = 2'd2; end
            5'd15: begin op_sel = OP_UC; lane_sel = 2'd2; end
            5'd16: op_sel = OP_AD;
            5'd17: op_sel = OP_VD;
            5'd18: op_sel = OP_PRED;
            5'd19: op_sel = OP_BQ1;
            5'd20: op_sel = OP_BQ2;
            5'd21: op_sel = OP_BM;
            5'd22: op_sel = OP_BY;
            5'd23: op_sel = OP_DIV3;
            5'd24: op_sel = OP_AQ1;
            5'd25: op_sel = OP_AQ2;
            default: op_sel = OP_BARO;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        cmd.op         = op_sel;
        cmd.lane       = lane_sel;
        cmd.wb         = 1'b0;
        cmd.capture    = accept;
        cmd.load_out   = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                step_next  = 5'd0;
                phase_next = 1'b0;
                if (accept)
                begin
                    state_next = in_ready_req ? S_RUN : S_FIN;
                end
            end
            S_RUN:
            begin
                cmd.wb     = phase_reg;
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        step_next = step_reg + 5'd1;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 5'd0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `AIF_ASSERT_NEXT(a_skip_goes_fin, clk, rst_n, accept && !in_ready_req, state_reg == S_FIN)
    `AIF_ASSERT_IMPL(a_step_in_range, clk, rst_n, state_reg == S_RUN, step_reg <= LAST_STEP)
    `AIF_ASSERT_IMPL(a_load_slot_free, clk, rst_n, cmd.load_out, !out_valid_reg || out_ready)
    `AIF_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid_reg && !out_ready, out_valid_reg)

endmodule

>>> sv/aif_datapath.sv
// ---------------------------------------------------------------------------
// Altitude inertial filter datapath
// Filter state, settings, one shared multiplier and the writeback logic.
// ---------------------------------------------------------------------------
module aif_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  aif_pkg::cmd_t cmd,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [23:0]   cfg_data,
    aif_in_if.sink        in_ch,
    output logic signed [31:0] est_position,
    output logic signed [31:0] est_velocity,
    output logic signed [31:0] est_accel,
    output logic               updated
);
    import aif_pkg::*;

    logic [23:0] wb_reg, wa_reg, wk_reg, grav_reg;

    logic signed [31:0] pos_reg, pos_next, vel_reg, vel_next, acc_reg, acc_next;
    logic signed [31:0] bc_reg, bc_next, ac_reg, ac_next;
    logic signed [31:0] bb_reg [3];
    logic signed [31:0] bb_next [3];
    logic signed [31:0] t_reg, t_next, u_reg, u_next, ad_reg, ad_next;
    logic signed [51:0] sum_reg, sum_next;
    logic signed [66:0] p_reg;

    logic [15:0]        dt_reg;
    logic               rdy_reg, bval_reg, aval_reg;
    logic signed [31:0] balt_reg;
    logic signed [23:0] a_in_reg [3];
    logic signed [15:0] rot_reg [3];

    logic signed [31:0] o_pos_reg, o_vel_reg, o_acc_reg;
    logic               o_upd_reg;

    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [31:0] bb_sum;
    wide_t              p_w;

    assign p_w = wide_t'(p_reg);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = 34'(t_reg);
        mul_b = {17'd0, dt_reg};
        case (cmd.op)
            OP_SUM:
            begin
                mul_a = 34'(a_in_reg[cmd.lane]) - 34'(bb_reg[cmd.lane]);
                mul_b = 33'(rot_reg[cmd.lane]);
            end
            OP_T1, OP_BQ1: begin mul_a = 34'(bc_reg); mul_b = {9'd0, wb_reg}; end
            OP_T2:         begin mul_a = 34'(t_reg);  mul_b = {9'd0, wb_reg}; end
            OP_UA:         begin mul_a = 34'(t_reg);  mul_b = 33'(rot_reg[cmd.lane]); end
            OP_UB:         begin mul_a = 34'(u_reg);  mul_b = {9'd0, wk_reg}; end
            OP_UC:         begin mul_a = 34'(u_reg);  mul_b = {17'd0, dt_reg}; end
            OP_AD:         begin mul_a = 34'(acc_reg); mul_b = {17'd0, dt_reg}; end
            OP_VD:         begin mul_a = 34'(vel_reg); mul_b = {17'd0, dt_reg}; end
            OP_PRED:       begin mul_a = 34'(ad_reg); mul_b = {17'd0, dt_reg}; end
            OP_BM, OP_BY:  begin mul_a = 34'(u_reg);  mul_b = {9'd0, wb_reg}; end
            OP_DIV3:       begin mul_a = 34'(t_reg);  mul_b = DIV3_MAGIC; end
            OP_AQ1:        begin mul_a = 34'(ac_reg); mul_b = {9'd0, wa_reg}; end
            default:       begin mul_a = 34'(t_reg);  mul_b = {17'd0, dt_reg}; end
        endcase
    end

    assign bb_sum = sat32(wide_t'(bb_reg[cmd.lane]) + wide_t'(sat32(p_w >>> 16)));

    // Writeback of the product formed in the previous cycle.
    always_comb
    begin
        pos_next = pos_reg;
        vel_next = vel_reg;
        acc_next = acc_reg;
        bc_next  = bc_reg;
        ac_next  = ac_reg;
        t_next   = t_reg;
        u_next   = u_reg;
        ad_next  = ad_reg;
        sum_next = sum_reg;
        for (int i = 0; i < 3; i++)
        begin
            bb_next[i] = bb_reg[i];
        end
        if (cmd.wb)
        begin
            case (cmd.op)
                OP_BARO:
                begin
                    if (bval_reg)
                    begin
                        bc_next = sat32(-wide_t'(balt_reg) - wide_t'(pos_reg));
                    end
                end
                OP_SUM:
                begin
                    sum_next = (cmd.lane == 2'd0) ? p_reg[51:0] : sum_reg + p_reg[51:0];
                end
                OP_ACORR:
                begin
                    if (aval_reg)
                    begin
                        ac_next = sat32(-wide_t'(sum_reg >>> 14) + wide_t'(grav_reg)
                                        - wide_t'(acc_reg));
                    end
                end
                OP_T1, OP_BQ1, OP_AQ1, OP_BY: t_next = sat32(p_w >>> 16);
                OP_T2:   t_next = sat32(-wide_t'(sat32(p_w >>> 16)));
                OP_UA:   u_next = sat32(p_w >>> 14);
                OP_UB:   u_next = sat32(p_w >>> 16);
                OP_UC:
                begin
                    if (cmd.lane == 2'd2)
                    begin
                        bb_next[2] = sat32(-wide_t'(bb_sum));
                    end
                    else
                    begin
                        bb_next[cmd.lane] = bb_sum;
                    end
                end
                OP_AD:   ad_next = sat32(p_w >>> 16);
                OP_VD:   u_next  = sat32(p_w >>> 16);
                OP_PRED:
                begin
                    pos_next = sat32(wide_t'(pos_reg) + wide_t'(u_reg)
                                     + wide_t'(sat32(p_w >>> 17)));
                    vel_next = sat32(wide_t'(vel_reg) + wide_t'(ad_reg));
                end
                OP_BQ2:
                begin
                    u_next   = sat32(p_w >>> 16);
                    pos_next = sat32(wide_t'(pos_reg) + wide_t'(sat32(p_w >>> 16)));
                end
                OP_BM:
                begin
                    u_next   = sat32(p_w >>> 16);
                    vel_next = sat32(wide_t'(vel_reg) + wide_t'(sat32(p_w >>> 16)));
                end
                OP_DIV3:
                begin
                    acc_next = sat32(wide_t'(acc_reg) + (p_w >>> 32)
                                     + wide_t'({1'b0, t_reg[31]}));
                end
                OP_AQ2:
                begin
                    acc_next = sat32(wide_t'(acc_reg) + wide_t'(sat32(p_w >>> 16)));
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_reg   <= 24'd32768;
            wa_reg   <= 24'd1310720;
            wk_reg   <= 24'd3277;
            grav_reg <= 24'd642689;
            pos_reg  <= '0;
            vel_reg  <= '0;
            acc_reg  <= '0;
            bc_reg   <= '0;
            ac_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                bb_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BARO_W:  wb_reg   <= cfg_data;
                    REG_ACCEL_W: wa_reg   <= cfg_data;
                    REG_BIAS_W:  wk_reg   <= cfg_data;
                    REG_GRAVITY: grav_reg <= cfg_data;
                    default:     grav_reg <= grav_reg;
                endcase
            end
            pos_reg <= pos_next;
            vel_reg <= vel_next;
            acc_reg <= acc_next;
            bc_reg  <= bc_next;
            ac_reg  <= ac_next;
            for (int i = 0; i < 3; i++)
            begin
                bb_reg[i] <= bb_next[i];
            end
        end
    end

    // Working and payload registers need no reset.
    always_ff @(posedge clk)
    begin
        p_reg   <= mul_a * mul_b;
        t_reg   <= t_next;
        u_reg   <= u_next;
        ad_reg  <= ad_next;
        sum_reg <= sum_next;
        if (cmd.capture)
        begin
            dt_reg      <= in_ch.elapsed;
            rdy_reg     <= in_ch.ready_req;
            bval_reg    <= in_ch.baro_valid;
            balt_reg    <= in_ch.baro_altitude;
            aval_reg    <= in_ch.accel_valid;
            a_in_reg[0] <= in_ch.accel_x;
            a_in_reg[1] <= in_ch.accel_y;
            a_in_reg[2] <= in_ch.accel_z;
            rot_reg[0]  <= in_ch.rot_x_col;
            rot_reg[1]  <= in_ch.rot_y_col;
            rot_reg[2]  <= in_ch.rot_z_col;
        end
        if (cmd.load_out)
        begin
            o_pos_reg <= pos_reg;
            o_vel_reg <= vel_reg;
            o_acc_reg <= acc_reg;
            o_upd_reg <= rdy_reg;
        end
    end

    assign est_position = o_pos_reg;
    assign est_velocity = o_vel_reg;
    assign est_accel    = o_acc_reg;
    assign updated      = o_upd_reg;

endmodule

>>> sv/altitude_inertial_filter_core.sv
// ---------------------------------------------------------------------------
// Altitude inertial filter core
// Third-order inertial complementary filter for the vertical axis, Q16.16.
// ---------------------------------------------------------------------------
// Each input transfer is one update tick and produces exactly one result
// transfer carrying the position, velocity and acceleration estimate and an
// updated flag. A tick with ready_req set runs a fixed program of 26
// operations on one shared signed multiplier, each a multiply phase and
// then a writeback phase, and then hands the estimate to the output
// register. A tick with ready_req low changes no filter state and goes
// from the accept straight to the output hand-over. The output register
// holds a finished estimate until it is taken; the next tick is accepted
// as soon as the previous one has been handed to that register. Settings
// are written through the plain write port (index 0 baro weight, 1 accel
// weight, 2 bias weight, 3 gravity) and must only be changed while no tick
// is in progress.
// ---------------------------------------------------------------------------
module altitude_inertial_filter_core (
    input  logic        clk,
    input  logic        rst_n,
    aif_in_if.sink      in_ch,
    aif_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import aif_pkg::*;

    cmd_t cmd;

    // The controller owns both handshakes and issues one command per cycle.
    aif_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_ready     (in_ch.ready),
        .in_ready_req (in_ch.ready_req),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .cmd          (cmd)
    );

    // The datapath holds the filter state, the settings and the output payload.
    aif_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_ch        (in_ch),
        .est_position (out_ch.est_position),
        .est_velocity (out_ch.est_velocity),
        .est_accel    (out_ch.est_accel),
        .updated      (out_ch.updated)
    );

endmodule
